/* design/magnet_grab_hold_throw_ctrl_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the magnet grab/hold/throw controller
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MAGNET_GRAB_HOLD_THROW_CTRL_ASSERT_SVH
`define MAGNET_GRAB_HOLD_THROW_CTRL_ASSERT_SVH

// same-cycle implication
`define MGHTC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mghtc assertion failed");

// next-cycle implication
`define MGHTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mghtc assertion failed");

`endif

/* design/mghtc_pkg.sv */
// ----------------------------------------------------------------------------
// mghtc_pkg
// Types, codes and constants of the magnet grab/hold/throw controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mghtc_pkg;

    // command codes
    localparam logic [3:0] CMD_POLL     = 4'd0;
    localparam logic [3:0] CMD_DUTY     = 4'd1;
    localparam logic [3:0] CMD_CATCH    = 4'd2;
    localparam logic [3:0] CMD_HOLD     = 4'd3;
    localparam logic [3:0] CMD_THROW    = 4'd4;
    localparam logic [3:0] CMD_DISARM   = 4'd5;
    localparam logic [3:0] CMD_RESET    = 4'd6;
    localparam logic [3:0] CMD_REFRESH  = 4'd7;
    localparam logic [3:0] CMD_LENGTHEN = 4'd8;
    localparam logic [3:0] CMD_SHORTEN  = 4'd9;
    localparam logic [3:0] CMD_FACTORY  = 4'd10;

    // channel modes
    localparam logic [2:0] M_OFF   = 3'd0;
    localparam logic [2:0] M_ARMED = 3'd1;
    localparam logic [2:0] M_GRAB  = 3'd2;
    localparam logic [2:0] M_PULSE = 3'd3;
    localparam logic [2:0] M_HOLD  = 3'd4;
    localparam logic [2:0] M_DROP  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_GRAB_POWER   = 3'd0;
    localparam logic [2:0] CFG_DEFAULT_HOLD = 3'd1;
    localparam logic [2:0] CFG_DROP_CH0     = 3'd2;
    localparam logic [2:0] CFG_DROP_CH1     = 3'd3;
    localparam logic [2:0] CFG_PULSE_TICKS  = 3'd4;
    localparam logic [2:0] CFG_THROW_ALLOW  = 3'd5;
    localparam logic [2:0] CFG_AUTO_LEARN   = 3'd6;

    localparam logic [7:0] LEARN_RST_CH0    = 8'd22;
    localparam logic [7:0] LEARN_RST_OTHER  = 8'd32;
    localparam logic [7:0] PULSE_BALL_LIMIT = 8'd5;
    localparam logic [7:0] HOLD_SEC_MAX     = 8'd2;
    localparam logic [7:0] TICKS_ONE_SEC    = 8'd250;
    localparam logic [7:0] TICKS_MAX        = 8'd255;

    typedef struct packed {
        logic [3:0] command;
        logic       channel;
        logic       ball_present;
        logic [7:0] hold_seconds;
    } t_in_item;

    typedef struct packed {
        logic       coil_on;
        logic [2:0] mode;
        logic       busy_res;
        logic [7:0] learned_delay;
    } t_out_item;

    typedef struct packed {
        logic [7:0] grab_power_ticks;
        logic [7:0] default_hold_ticks;
        logic [7:0] drop_ticks_ch0;
        logic [7:0] drop_ticks_ch1;
        logic [7:0] throw_pulse_ticks;
        logic       throw_allowed;
        logic       auto_learn;
    } t_cfg;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] power_count;
        logic [7:0] hold_count;
        logic       throw_armed;
        logic       coil_level;
        logic [7:0] learned;
    } t_chan;

    function automatic logic is_busy(input logic [2:0] mode);
        return (mode >= M_GRAB) && (mode <= M_DROP);
    endfunction

endpackage

`default_nettype wire

/* design/mghtc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mghtc_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mghtc_cfg_regs (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [2:0]       i_wr_index,
    input  wire logic [7:0]       i_wr_data,
    output mghtc_pkg::t_cfg       o_cfg
);
    import mghtc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grab_power_ticks   <= 8'd128;
            r_cfg.default_hold_ticks <= 8'd128;
            r_cfg.drop_ticks_ch0     <= 8'd64;
            r_cfg.drop_ticks_ch1     <= 8'd49;
            r_cfg.throw_pulse_ticks  <= 8'd8;
            r_cfg.throw_allowed      <= 1'b1;
            r_cfg.auto_learn         <= 1'b1;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_GRAB_POWER:   r_cfg.grab_power_ticks   <= i_wr_data;
                CFG_DEFAULT_HOLD: r_cfg.default_hold_ticks <= i_wr_data;
                CFG_DROP_CH0:     r_cfg.drop_ticks_ch0     <= i_wr_data;
                CFG_DROP_CH1:     r_cfg.drop_ticks_ch1     <= i_wr_data;
                CFG_PULSE_TICKS:  r_cfg.throw_pulse_ticks  <= i_wr_data;
                CFG_THROW_ALLOW:  r_cfg.throw_allowed      <= i_wr_data[0];
                CFG_AUTO_LEARN:   r_cfg.auto_learn         <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/mghtc_chan_update.sv */
// ----------------------------------------------------------------------------
// mghtc_chan_update
// Next state of the addressed channel for the channel-local commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mghtc_chan_update (
    input  wire logic [3:0]       i_cmd,
    input  wire logic             i_ball,
    input  wire logic [7:0]       i_secs,
    input  wire logic             i_is_ch0,
    input  wire mghtc_pkg::t_cfg  i_cfg,
    input  wire mghtc_pkg::t_chan i_chan,
    output mghtc_pkg::t_chan      o_chan
);
    import mghtc_pkg::*;

    logic [7:0] pc_dec;
    logic [7:0] hc_dec;
    logic [7:0] hc_inc;
    logic [8:0] drop_sum;
    logic [7:0] drop_sat;
    logic [7:0] secs_ticks;

    assign pc_dec   = i_chan.power_count - 8'd1;
    assign hc_dec   = i_chan.hold_count - 8'd1;
    assign hc_inc   = i_ball ? (i_chan.hold_count + 8'd1) : i_chan.hold_count;
    assign drop_sum = {1'b0, (i_is_ch0 ? i_cfg.drop_ticks_ch0 : i_cfg.drop_ticks_ch1)}
                    + {1'b0, i_chan.learned};
    assign drop_sat = drop_sum[8] ? TICKS_MAX : drop_sum[7:0];

    always_comb begin
        if (i_secs >= HOLD_SEC_MAX) begin
            secs_ticks = TICKS_MAX;
        end else if (i_secs == 8'd1) begin
            secs_ticks = TICKS_ONE_SEC;
        end else begin
            secs_ticks = 8'd0;
        end
    end

    always_comb begin
        o_chan = i_chan;
        case (i_cmd)
            CMD_POLL: begin
                if (i_chan.mode == M_ARMED && i_ball) begin
                    o_chan.coil_level  = 1'b1;
                    o_chan.mode        = M_GRAB;
                    o_chan.power_count = i_cfg.grab_power_ticks;
                end
            end
            CMD_DUTY: begin
                case (i_chan.mode)
                    M_GRAB: begin
                        o_chan.power_count = pc_dec;
                        if (pc_dec == 8'd0) begin
                            if (!i_ball) begin
                                o_chan.coil_level  = 1'b0;
                                o_chan.throw_armed = 1'b0;
                                o_chan.mode        = M_OFF;
                            end else if (i_chan.throw_armed) begin
                                o_chan.throw_armed = 1'b0;
                                o_chan.hold_count  = drop_sat;
                                o_chan.coil_level  = 1'b0;
                                o_chan.mode        = M_DROP;
                            end else begin
                                o_chan.mode = M_HOLD;
                            end
                        end
                    end
                    M_PULSE: begin
                        o_chan.hold_count  = hc_inc;
                        o_chan.power_count = pc_dec;
                        if (pc_dec == 8'd0 || hc_inc > PULSE_BALL_LIMIT) begin
                            o_chan.coil_level = 1'b0;
                            o_chan.mode       = M_OFF;
                        end
                    end
                    M_HOLD: begin
                        o_chan.hold_count = hc_dec;
                        if (hc_dec == 8'd0) begin
                            o_chan.mode = M_OFF;
                        end else begin
                            o_chan.coil_level = hc_dec[0];
                        end
                    end
                    M_DROP: begin
                        o_chan.hold_count = hc_dec;
                        if (hc_dec == 8'd0) begin
                            o_chan.power_count = i_cfg.throw_pulse_ticks;
                            o_chan.coil_level  = 1'b1;
                            o_chan.mode        = M_PULSE;
                        end
                    end
                    default: begin
                        o_chan.coil_level = 1'b0;
                    end
                endcase
            end
            CMD_CATCH: begin
                o_chan.hold_count = i_cfg.default_hold_ticks;
                o_chan.mode       = M_ARMED;
            end
            CMD_HOLD: begin
                o_chan.hold_count = secs_ticks;
                o_chan.mode       = M_ARMED;
            end
            CMD_THROW: begin
                if (i_cfg.throw_allowed) begin
                    o_chan.throw_armed = 1'b1;
                    o_chan.mode        = M_ARMED;
                end
            end
            CMD_DISARM: begin
                if (!is_busy(i_chan.mode)) begin
                    o_chan.mode = M_OFF;
                end
            end
            CMD_LENGTHEN: begin
                if (i_cfg.auto_learn && i_chan.learned != TICKS_MAX) begin
                    o_chan.learned = i_chan.learned + 8'd1;
                end
            end
            CMD_SHORTEN: begin
                if (i_cfg.auto_learn && i_chan.learned != 8'd0) begin
                    o_chan.learned = i_chan.learned - 8'd1;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* design/magnet_grab_hold_throw_ctrl.sv */
// ----------------------------------------------------------------------------
// magnet_grab_hold_throw_ctrl
// Result path: input register, then result register; an output stall holds the command in the input register.
// Throughput: one command per cycle while the output is not stalled; channel state is registered when a command fires.
// Reset (sync, active low) restores register defaults and all channel state.
// ----------------------------------------------------------------------------
`default_nettype none

module magnet_grab_hold_throw_ctrl #(
    parameter int NUM_CHANNELS = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire mghtc_pkg::t_in_item i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output mghtc_pkg::t_out_item  o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [7:0]       i_cfg_data
);
    import mghtc_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item n_out;
    t_chan     r_chan [NUM_CHANNELS];
    t_chan     n_chan [NUM_CHANNELS];
    t_chan     cur_chan;
    t_chan     upd_chan;
    logic      fire;
    logic      in_accept;
    logic      in_range;
    logic [CH_W-1:0] sel;

    assign o_cfg_ready = 1'b1;

    mghtc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_range   = int'(r_in.channel) < NUM_CHANNELS;
    assign sel        = CH_W'(r_in.channel);
    assign cur_chan   = r_chan[sel];

    mghtc_chan_update u_upd (
        .i_cmd    (r_in.command),
        .i_ball   (r_in.ball_present),
        .i_secs   (r_in.hold_seconds),
        .i_is_ch0 (r_in.channel == 1'b0),
        .i_cfg    (cfg),
        .i_chan   (cur_chan),
        .o_chan   (upd_chan)
    );

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            n_chan[i] = r_chan[i];
            if (in_range) begin
                if (CH_W'(i) == sel) begin
                    n_chan[i] = upd_chan;
                end
                case (r_in.command)
                    CMD_RESET: begin
                        n_chan[i].mode        = M_OFF;
                        n_chan[i].power_count = 8'd0;
                        n_chan[i].hold_count  = 8'd0;
                        n_chan[i].throw_armed = 1'b0;
                    end
                    CMD_REFRESH: begin
                        n_chan[i].hold_count = cfg.default_hold_ticks;
                    end
                    CMD_FACTORY: begin
                        n_chan[i].learned = (i == 0) ? LEARN_RST_CH0 : LEARN_RST_OTHER;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_out = '0;
        if (in_range) begin
            n_out.coil_on       = n_chan[sel].coil_level;
            n_out.mode          = n_chan[sel].mode;
            n_out.busy_res      = is_busy(n_chan[sel].mode);
            n_out.learned_delay = n_chan[sel].learned;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_chan[i].mode        <= M_OFF;
                r_chan[i].power_count <= 8'd0;
                r_chan[i].hold_count  <= 8'd0;
                r_chan[i].throw_armed <= 1'b0;
                r_chan[i].coil_level  <= 1'b0;
                r_chan[i].learned     <= (i == 0) ? LEARN_RST_CH0 : LEARN_RST_OTHER;
            end
        end else if (fire) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_chan[i] <= n_chan[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !fire);
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* design/mghtc_checker.sv */
// ----------------------------------------------------------------------------
// mghtc_checker
// Port-level checks of the magnet controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "magnet_grab_hold_throw_ctrl_assert.svh"

module mghtc_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             o_in_stall,
    input  wire logic             o_out_valid,
    input  wire logic             i_out_stall,
    input  wire mghtc_pkg::t_out_item o_out_data
);
    import mghtc_pkg::*;

    `MGHTC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `MGHTC_ASSERT_NOW(a_busy_mode, o_out_valid, o_out_data.busy_res == is_busy(o_out_data.mode))
    `MGHTC_ASSERT_NOW(a_grab_coil, o_out_valid && o_out_data.mode == M_GRAB, o_out_data.coil_on)
    `MGHTC_ASSERT_NOW(a_drop_coil, o_out_valid && o_out_data.mode == M_DROP, !o_out_data.coil_on)
    `MGHTC_ASSERT_NOW(a_no_stall_empty, !o_out_valid, !o_in_stall)

endmodule

bind magnet_grab_hold_throw_ctrl mghtc_checker u_mghtc_checker (.*);

`default_nettype wire
